FILE: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the command frame receiver: frame state,
// result record, item kinds, status codes and frame layout positions.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int TIMEOUT_W       = 16;
  localparam int IDX_W           = 7;
  localparam int LEN_W           = 6;
  localparam int STATUS_W        = 2;

  // item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // frame status
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CKSUM_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 2'd2;

  // frame positions
  localparam logic [IDX_W-1:0] IDX_IDLE  = 7'd0;
  localparam logic [IDX_W-1:0] IDX_CODE  = 7'd1;
  localparam logic [IDX_W-1:0] IDX_CKSUM = 7'd2;
  localparam logic [IDX_W-1:0] IDX_MAX   = 7'd65;

  // code byte layout
  localparam int CODE_CKSUM_BIT = 7;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       held_command;
    logic [7:0]       held_code;
    logic [7:0]       received_checksum;
    logic [7:0]       running_sum;
  } frame_state_t;

  typedef struct packed {
    logic                payload_valid;
    logic [7:0]          payload_byte;
    logic                frame_end;
    logic [STATUS_W-1:0] status;
    logic [7:0]          command_code;
    logic [LEN_W-1:0]    payload_length;
    logic                checksum_used;
    logic [7:0]          computed_checksum;
  } frame_result_t;

  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

FILE: rtl/cfr_frame_step.sv
// ----------------------------------------------------------------------------
// cfr_frame_step
// Next-state and result logic for one byte or tick of the frame receiver.
// ----------------------------------------------------------------------------
module cfr_frame_step #(
  parameter int TIMER_WIDTH = cfr_pkg::TIMER_WIDTH_DEF
) (
  input  cfr_pkg::frame_state_t           state,
  input  logic [TIMER_WIDTH-1:0]          idle_ticks,
  input  logic [cfr_pkg::TIMEOUT_W-1:0]   receive_timeout,
  input  logic                            command,
  input  logic [7:0]                      rx_byte,
  output cfr_pkg::frame_state_t           state_nxt,
  output logic [TIMER_WIDTH-1:0]          idle_ticks_nxt,
  output logic                            emit,
  output cfr_pkg::frame_result_t          result
);

  localparam int CMP_W = (TIMER_WIDTH > cfr_pkg::TIMEOUT_W) ? TIMER_WIDTH : cfr_pkg::TIMEOUT_W;

  logic [TIMER_WIDTH-1:0] idle_inc;
  logic                   timed_out;
  logic                   used;
  logic [cfr_pkg::LEN_W-1:0] len;
  logic [7:0]             first_payload;
  logic [7:0]             sum_payload;
  logic                   last_payload;
  logic                   do_close;
  logic [7:0]             close_sum;
  logic [7:0]             close_code;
  logic [7:0]             close_rx_ck;
  logic [7:0]             ck;

  assign idle_inc  = (&idle_ticks) ? idle_ticks : idle_ticks + 1'b1;
  assign timed_out = (receive_timeout != '0) &&
                     (CMP_W'(idle_inc) > CMP_W'(receive_timeout));

  assign used          = state.held_code[cfr_pkg::CODE_CKSUM_BIT];
  assign len           = state.held_code[cfr_pkg::LEN_W-1:0];
  assign first_payload = used ? 8'd3 : 8'd2;
  assign sum_payload   = cfr_pkg::eac_add(state.running_sum, rx_byte);
  assign last_payload  = ({1'b0, state.byte_index} + 8'd1) >= (first_payload + {2'd0, len});

  assign ck = ~close_sum;

  always_comb begin
    state_nxt      = state;
    idle_ticks_nxt = idle_ticks;
    emit           = 1'b0;
    result         = '0;
    do_close       = 1'b0;
    close_sum      = state.running_sum;
    close_code     = state.held_code;
    close_rx_ck    = state.received_checksum;

    if (command == cfr_pkg::CMD_TICK) begin
      if (state.byte_index != cfr_pkg::IDX_IDLE) begin
        if (timed_out) begin
          emit                  = 1'b1;
          result.frame_end      = 1'b1;
          result.status         = cfr_pkg::ST_TIMEOUT;
          result.command_code   = state.held_command;
          if (state.byte_index >= cfr_pkg::IDX_CKSUM) begin
            result.payload_length = len;
            result.checksum_used  = used;
          end
          state_nxt.byte_index = cfr_pkg::IDX_IDLE;
          idle_ticks_nxt       = '0;
        end else begin
          idle_ticks_nxt = idle_inc;
        end
      end
    end else begin
      idle_ticks_nxt = '0;
      if (state.byte_index == cfr_pkg::IDX_IDLE) begin
        state_nxt.held_command = rx_byte;
        state_nxt.byte_index   = cfr_pkg::IDX_CODE;
      end else if (state.byte_index == cfr_pkg::IDX_CODE) begin
        state_nxt.held_code   = rx_byte;
        state_nxt.running_sum = cfr_pkg::eac_add(state.held_command, rx_byte);
        state_nxt.byte_index  = cfr_pkg::IDX_CKSUM;
        close_code            = rx_byte;
        close_sum             = state_nxt.running_sum;
        do_close = !rx_byte[cfr_pkg::CODE_CKSUM_BIT] && (rx_byte[cfr_pkg::LEN_W-1:0] == '0);
      end else if (used && state.byte_index == cfr_pkg::IDX_CKSUM) begin
        state_nxt.received_checksum = rx_byte;
        state_nxt.byte_index        = state.byte_index + 1'b1;
        close_rx_ck                 = rx_byte;
        do_close                    = (len == '0);
      end else begin
        state_nxt.running_sum = sum_payload;
        close_sum             = sum_payload;
        emit                  = 1'b1;
        result.payload_valid  = 1'b1;
        result.payload_byte   = rx_byte;
        do_close              = last_payload;
        state_nxt.byte_index  = state.byte_index + 1'b1;
      end

      if (do_close) begin
        emit                     = 1'b1;
        result.frame_end         = 1'b1;
        result.status            = (close_code[cfr_pkg::CODE_CKSUM_BIT] && ck != close_rx_ck) ?
                                   cfr_pkg::ST_CKSUM_ERR : cfr_pkg::ST_OK;
        result.command_code      = state.held_command;
        result.payload_length    = close_code[cfr_pkg::LEN_W-1:0];
        result.checksum_used     = close_code[cfr_pkg::CODE_CKSUM_BIT];
        result.computed_checksum = ck;
        state_nxt.byte_index     = cfr_pkg::IDX_IDLE;
      end
    end
  end

endmodule

FILE: rtl/command_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// command_frame_receiver_core
// Command frame receiver: command byte, code byte, optional ones' complement
// checksum byte and payload; payload bytes forwarded, frame end reported
// with status; ticks time out a partial frame.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | input     | in_valid / in_ready  | command, rx_byte
//   out_    | output    | out_valid / out_ready| payload, frame end and status
//   cfg_    | input     | cfg_valid / cfg_ready| receive_timeout (16 bits)
//
// one item per cycle while out_ready does not stall a result: an input register
// feeds the step logic, whose result is registered in an output register
// items without a result retire without waiting on the output side
// out_ready low stalls only items that produce a result
// synchronous active-low reset clears frame state, timer and timeout register
// ----------------------------------------------------------------------------
module command_frame_receiver_core #(
  parameter int TIMER_WIDTH = cfr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_payload_valid,
  output logic [7:0]                        out_payload_byte,
  output logic                              out_frame_end,
  output logic [cfr_pkg::STATUS_W-1:0]      out_status,
  output logic [7:0]                        out_command_code,
  output logic [cfr_pkg::LEN_W-1:0]         out_payload_length,
  output logic                              out_checksum_used,
  output logic [7:0]                        out_computed_checksum,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfr_pkg::TIMEOUT_W-1:0]     cfg_wdata
);

  cfr_pkg::frame_state_t           state_r;
  cfr_pkg::frame_state_t           state_nxt;
  logic [TIMER_WIDTH-1:0]          idle_ticks_r;
  logic [TIMER_WIDTH-1:0]          idle_ticks_nxt;
  logic [cfr_pkg::TIMEOUT_W-1:0]   timeout_r;
  logic                            in_valid_r;
  logic                            in_command_r;
  logic [7:0]                      in_rx_byte_r;
  logic                            out_valid_r;
  cfr_pkg::frame_result_t          out_res_r;
  cfr_pkg::frame_result_t          res;
  logic                            emit;
  logic                            out_free;
  logic                            advance;

  cfr_frame_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .state           (state_r),
    .idle_ticks      (idle_ticks_r),
    .receive_timeout (timeout_r),
    .command         (in_command_r),
    .rx_byte         (in_rx_byte_r),
    .state_nxt       (state_nxt),
    .idle_ticks_nxt  (idle_ticks_nxt),
    .emit            (emit),
    .result          (res)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = in_valid_r && (!emit || out_free);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      idle_ticks_r <= '0;
      timeout_r    <= '0;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_wdata;
      end
      if (advance) begin
        state_r      <= state_nxt;
        idle_ticks_r <= idle_ticks_nxt;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= advance && emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_command_r <= in_command;
      in_rx_byte_r <= in_rx_byte;
    end
    if (advance && emit && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_payload_valid     = out_res_r.payload_valid;
  assign out_payload_byte      = out_res_r.payload_byte;
  assign out_frame_end         = out_res_r.frame_end;
  assign out_status            = out_res_r.status;
  assign out_command_code      = out_res_r.command_code;
  assign out_payload_length    = out_res_r.payload_length;
  assign out_checksum_used     = out_res_r.checksum_used;
  assign out_computed_checksum = out_res_r.computed_checksum;

  a_idle_timer_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.byte_index == cfr_pkg::IDX_IDLE) |-> (idle_ticks_r == '0))
    else $error("timer running with no open frame");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_index <= cfr_pkg::IDX_MAX)
    else $error("frame position out of range");

  a_timeout_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cfr_pkg::ST_TIMEOUT) |->
      (out_frame_end && !out_payload_valid && out_computed_checksum == 8'd0))
    else $error("malformed timeout result");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |-> (out_status == cfr_pkg::ST_OK && out_payload_valid))
    else $error("status without frame end");

endmodule

FILE: tb/sv/cfr_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfr_result_checker
// Watches the input, result and timeout register channels of the command
// frame receiver. It tracks frame position, checksum sum and tick count on
// its own and queues the result each input transfer should cause. Every
// result transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module cfr_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_command,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_payload_valid,
  input  logic [7:0]                    out_payload_byte,
  input  logic                          out_frame_end,
  input  logic [cfr_pkg::STATUS_W-1:0]  out_status,
  input  logic [7:0]                    out_command_code,
  input  logic [cfr_pkg::LEN_W-1:0]     out_payload_length,
  input  logic                          out_checksum_used,
  input  logic [7:0]                    out_computed_checksum,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cfr_pkg::TIMEOUT_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            due_count
);

  cfr_pkg::frame_result_t                frames_due[$];
  logic [cfr_pkg::IDX_W-1:0]             frame_pos;
  logic [7:0]                            cmd_hold;
  logic [7:0]                            code_hold;
  logic [7:0]                            cksum_hold;
  logic [7:0]                            sum_acc;
  logic [cfr_pkg::TIMER_WIDTH_DEF-1:0]   tick_count;
  logic [cfr_pkg::TIMEOUT_W-1:0]         timeout_limit;

  function automatic logic [7:0] wrap_add(input logic [7:0] a, input logic [7:0] b);
    int t;
    t = int'(a) + int'(b);
    if (t > 255) t = t - 255;
    return t[7:0];
  endfunction

  task automatic seal_frame(inout cfr_pkg::frame_result_t r);
    logic [7:0] ck;
    ck = ~sum_acc;
    r.frame_end         = 1'b1;
    r.status            = (code_hold[cfr_pkg::CODE_CKSUM_BIT] && ck != cksum_hold) ?
                          cfr_pkg::ST_CKSUM_ERR : cfr_pkg::ST_OK;
    r.command_code      = cmd_hold;
    r.payload_length    = code_hold[cfr_pkg::LEN_W-1:0];
    r.checksum_used     = code_hold[cfr_pkg::CODE_CKSUM_BIT];
    r.computed_checksum = ck;
    frame_pos  = cfr_pkg::IDX_IDLE;
    tick_count = '0;
    frames_due.push_back(r);
  endtask

  task automatic step_frame(input logic kind, input logic [7:0] data);
    cfr_pkg::frame_result_t    r;
    logic [cfr_pkg::LEN_W-1:0] len;
    logic                      has_ck;
    logic [cfr_pkg::IDX_W-1:0] last_pos;
    r = '0;
    if (kind == cfr_pkg::CMD_TICK) begin
      if (frame_pos != cfr_pkg::IDX_IDLE) begin
        if (tick_count != '1) tick_count = tick_count + 1'b1;
        if (timeout_limit != 0 && tick_count > timeout_limit) begin
          r.frame_end    = 1'b1;
          r.status       = cfr_pkg::ST_TIMEOUT;
          r.command_code = cmd_hold;
          if (frame_pos >= cfr_pkg::IDX_CKSUM) begin
            r.payload_length = code_hold[cfr_pkg::LEN_W-1:0];
            r.checksum_used  = code_hold[cfr_pkg::CODE_CKSUM_BIT];
          end
          frame_pos  = cfr_pkg::IDX_IDLE;
          tick_count = '0;
          frames_due.push_back(r);
        end
      end
    end else begin
      tick_count = '0;
      if (frame_pos == cfr_pkg::IDX_IDLE) begin
        cmd_hold  = data;
        frame_pos = cfr_pkg::IDX_CODE;
      end else if (frame_pos == cfr_pkg::IDX_CODE) begin
        code_hold = data;
        sum_acc   = wrap_add(cmd_hold, data);
        frame_pos = cfr_pkg::IDX_CKSUM;
        if (!data[cfr_pkg::CODE_CKSUM_BIT] && data[cfr_pkg::LEN_W-1:0] == 0) seal_frame(r);
      end else begin
        len    = code_hold[cfr_pkg::LEN_W-1:0];
        has_ck = code_hold[cfr_pkg::CODE_CKSUM_BIT];
        if (has_ck && frame_pos == cfr_pkg::IDX_CKSUM) begin
          cksum_hold = data;
          frame_pos  = cfr_pkg::IDX_CKSUM + 1'b1;
          if (len == 0) seal_frame(r);
        end else begin
          sum_acc         = wrap_add(sum_acc, data);
          r.payload_valid = 1'b1;
          r.payload_byte  = data;
          last_pos = cfr_pkg::IDX_CKSUM + cfr_pkg::IDX_W'(has_ck) + cfr_pkg::IDX_W'(len) - 1'b1;
          if (frame_pos >= last_pos) seal_frame(r);
          else begin
            frames_due.push_back(r);
            frame_pos = frame_pos + 1'b1;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cfr_pkg::frame_result_t want;
    if (!rst_n) begin
      frames_due.delete();
      frame_pos     = cfr_pkg::IDX_IDLE;
      cmd_hold      = '0;
      code_hold     = '0;
      cksum_hold    = '0;
      sum_acc       = '0;
      tick_count    = '0;
      timeout_limit = '0;
      fail_count    = 0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_limit = cfg_wdata;
      if (in_valid && in_ready) step_frame(in_command, in_rx_byte);
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t ns: result transfer with nothing due, expected none, actual %0h/%0h",
                   $time, out_payload_byte, out_command_code);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("payload_valid", want.payload_valid, out_payload_valid);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("status", want.status, out_status);
          check_field("command_code", want.command_code, out_command_code);
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("checksum_used", want.checksum_used, out_checksum_used);
          check_field("computed_checksum", want.computed_checksum, out_computed_checksum);
        end
      end
    end
    due_count = frames_due.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the command frame receiver: directed frames covering empty,
// checksummed, bad checksum and timed out frames, short tick runs against
// changed limits, then random frames with ticks, noise and cut frames under a
// range of timeout settings. Both channels idle at random; the checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 1000000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_command;
  logic [7:0]                    in_rx_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_payload_valid;
  logic [7:0]                    out_payload_byte;
  logic                          out_frame_end;
  logic [cfr_pkg::STATUS_W-1:0]  out_status;
  logic [7:0]                    out_command_code;
  logic [cfr_pkg::LEN_W-1:0]     out_payload_length;
  logic                          out_checksum_used;
  logic [7:0]                    out_computed_checksum;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cfr_pkg::TIMEOUT_W-1:0] cfg_wdata;

  int                            fail_count;
  int                            due_count;
  int                            cycle_count = 0;
  int                            items_sent = 0;
  bit                            calm = 1'b0;
  int                            hold_reqs = 0;
  int                            hold_taken = 0;
  int                            hold_left = 0;
  logic [cfr_pkg::TIMEOUT_W-1:0] cur_timeout = '0;

  command_frame_receiver_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_payload_valid     (out_payload_valid),
    .out_payload_byte      (out_payload_byte),
    .out_frame_end         (out_frame_end),
    .out_status            (out_status),
    .out_command_code      (out_command_code),
    .out_payload_length    (out_payload_length),
    .out_checksum_used     (out_checksum_used),
    .out_computed_checksum (out_computed_checksum),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_wdata             (cfg_wdata)
  );

  cfr_result_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_payload_valid     (out_payload_valid),
    .out_payload_byte      (out_payload_byte),
    .out_frame_end         (out_frame_end),
    .out_status            (out_status),
    .out_command_code      (out_command_code),
    .out_payload_length    (out_payload_length),
    .out_checksum_used     (out_checksum_used),
    .out_computed_checksum (out_computed_checksum),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .due_count             (due_count)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = 300;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 14);
    end
  end

  function automatic logic [7:0] sum_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[8] ? t[7:0] + 8'd1 : t[7:0];
  endfunction

  // called and returns at a falling edge
  task automatic push_item(input logic kind, input logic [7:0] data);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= kind;
    in_rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic gap_ticks(input int n);
    repeat (n) push_item(cfr_pkg::CMD_TICK, 8'($urandom_range(255)));
  endtask

  // stop sending and let every due result and the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [cfr_pkg::TIMEOUT_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    cur_timeout = value;
  endtask

  task automatic tick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 80) return;
    if (cur_timeout == 0 || cur_timeout > 16) gap_ticks($urandom_range(1, 3));
    else if (r < 95) gap_ticks($urandom_range(1, cur_timeout));
    else gap_ticks(cur_timeout + 1);
  endtask

  task automatic send_frame();
    logic [7:0] payload [0:63];
    logic [7:0] cmd;
    logic [7:0] code;
    logic [7:0] sum;
    logic [7:0] ck;
    logic [7:0] data;
    int         len;
    int         r;
    int         total;
    int         cut;
    int         hdr;
    if ($urandom_range(99) < 5) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 3) len = 63;
    else if (r < 8) len = $urandom_range(21, 62);
    else if (r < 33) len = $urandom_range(5, 20);
    else len = $urandom_range(0, 4);
    cmd  = 8'($urandom_range(255));
    code = {1'($urandom_range(1)), 1'($urandom_range(1)), 6'(len)};
    sum  = sum_add(cmd, code);
    for (int i = 0; i < len; i++) begin
      payload[i] = 8'($urandom_range(255));
      sum = sum_add(sum, payload[i]);
    end
    ck = ~sum;
    if ($urandom_range(99) < 20) ck = ck ^ 8'($urandom_range(1, 255));
    hdr   = 2 + code[cfr_pkg::CODE_CKSUM_BIT];
    total = hdr + len;
    cut   = ($urandom_range(99) < 5) ? $urandom_range(1, total - 1) : total;
    for (int k = 0; k < cut; k++) begin
      if (k == 0) data = cmd;
      else if (k == 1) data = code;
      else if (k < hdr) data = ck;
      else data = payload[k - hdr];
      push_item(cfr_pkg::CMD_BYTE, data);
      if (k < cut - 1) tick_burst();
    end
    if (cut == total && $urandom_range(99) < 10) gap_ticks($urandom_range(1, 3));
  endtask

  initial begin
    logic [7:0]                    sum;
    logic [cfr_pkg::TIMEOUT_W-1:0] tmo_list [0:6];
    int                            start;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = cfr_pkg::CMD_BYTE;
    in_rx_byte = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_wdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty frame closing on the code byte
    push_item(cfr_pkg::CMD_BYTE, 8'hFF);
    push_item(cfr_pkg::CMD_BYTE, 8'h00);
    // empty frame closing on the checksum byte
    push_item(cfr_pkg::CMD_BYTE, 8'h00);
    push_item(cfr_pkg::CMD_BYTE, 8'h80);
    push_item(cfr_pkg::CMD_BYTE, 8'h7F);
    // bad checksum, bit 6 set, extreme payload bytes
    push_item(cfr_pkg::CMD_BYTE, 8'hA5);
    push_item(cfr_pkg::CMD_BYTE, 8'hC2);
    push_item(cfr_pkg::CMD_BYTE, 8'h00);
    push_item(cfr_pkg::CMD_BYTE, 8'hFF);
    push_item(cfr_pkg::CMD_BYTE, 8'h00);
    // no checksum, frame closes on its only payload byte
    push_item(cfr_pkg::CMD_BYTE, 8'h5A);
    push_item(cfr_pkg::CMD_BYTE, 8'h01);
    push_item(cfr_pkg::CMD_BYTE, 8'h80);
    // tick with no frame open
    push_item(cfr_pkg::CMD_TICK, 8'hFF);
    // ticks inside a frame with the timeout off
    push_item(cfr_pkg::CMD_BYTE, 8'h12);
    push_item(cfr_pkg::CMD_TICK, 8'h00);
    push_item(cfr_pkg::CMD_BYTE, 8'h02);
    push_item(cfr_pkg::CMD_TICK, 8'h00);
    push_item(cfr_pkg::CMD_BYTE, 8'h34);
    push_item(cfr_pkg::CMD_TICK, 8'h00);
    push_item(cfr_pkg::CMD_BYTE, 8'h56);

    write_timeout(16'd1);
    // timeout before the code byte
    push_item(cfr_pkg::CMD_BYTE, 8'h33);
    gap_ticks(2);
    // timeout after the code byte
    push_item(cfr_pkg::CMD_BYTE, 8'h44);
    push_item(cfr_pkg::CMD_BYTE, 8'h85);
    gap_ticks(2);

    // idle tick counter runs with the timeout off, then fires against a lower limit
    write_timeout(16'd0);
    push_item(cfr_pkg::CMD_BYTE, 8'h11);
    gap_ticks(20);
    write_timeout(16'd10);
    push_item(cfr_pkg::CMD_TICK, 8'h00);

    // largest limit does not fire across a tick run
    write_timeout(16'hFFFF);
    push_item(cfr_pkg::CMD_BYTE, 8'h22);
    push_item(cfr_pkg::CMD_BYTE, 8'h83);
    gap_ticks(20);
    sum = sum_add(sum_add(sum_add(sum_add(8'h22, 8'h83), 8'h01), 8'h02), 8'h03);
    push_item(cfr_pkg::CMD_BYTE, ~sum);
    push_item(cfr_pkg::CMD_BYTE, 8'h01);
    push_item(cfr_pkg::CMD_BYTE, 8'h02);
    push_item(cfr_pkg::CMD_BYTE, 8'h03);

    tmo_list[0] = 16'd1;
    tmo_list[1] = 16'd2;
    tmo_list[2] = 16'd0;
    tmo_list[3] = 16'd7;
    tmo_list[4] = 16'($urandom_range(3, 12));
    tmo_list[5] = 16'($urandom_range(65535));
    tmo_list[6] = 16'd4;
    for (int p = 0; p < 7; p++) begin
      write_timeout(tmo_list[p]);
      calm  = (p == 2);
      start = items_sent;
      while (items_sent - start < 235) begin
        send_frame();
        if (p == 3 && items_sent - start >= 60 && hold_reqs == 0) hold_reqs++;
        if (p == 5 && items_sent - start >= 100 && items_sent - start < 110) settle();
      end
    end
    calm = 1'b0;

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cfr_pkg.sv
rtl/cfr_frame_step.sv
rtl/command_frame_receiver_core.sv
tb/sv/cfr_result_checker.sv
tb/sv/tb.sv
